/* sv/ipdu_pkg.sv */
package ipdu_pkg;

  // Fixed-point formats
  localparam int unsigned GAIN_W         = 22;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned ERR_FRAC_BITS  = 8;
  localparam int unsigned DUTY_FRAC_BITS = 16;
  localparam int unsigned PULSE_W        = 16;
  localparam int unsigned REF_W          = 24;
  localparam int unsigned LIMIT_W        = 8;
  localparam int unsigned ERR_W          = 26;
  localparam int unsigned DUTY_ACC_W     = 24;
  localparam int unsigned DUTY_W         = 8;
  localparam int unsigned SAT_W          = 2;

  // Shared multiplier operands and product
  localparam int unsigned MUL_A_W = GAIN_W + 1;
  localparam int unsigned MUL_B_W = ERR_W + 2;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = MUL_P_W + 6;

  // Increment shift from Q(GAIN_FRAC_BITS+8) to Q8.16
  localparam int unsigned INC_SHIFT = GAIN_FRAC_BITS + ERR_FRAC_BITS - DUTY_FRAC_BITS;

  // ki/40 = ((ki >> 3) * RECIP_5) >> RECIP_SHIFT, exact for 19-bit operands
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_5     = ((1 << RECIP_SHIFT) + 4) / 5;
  localparam int unsigned KIH_W       = GAIN_W - 5;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 2'd1;
  localparam logic [LIMIT_W-1:0]   DUTY_LIMIT_RST = 8'd250;

  // Saturation codes
  localparam logic [SAT_W-1:0] SAT_NONE = 2'd0;
  localparam logic [SAT_W-1:0] SAT_LOW  = 2'd1;
  localparam logic [SAT_W-1:0] SAT_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PTERM,
    ST_ITERM,
    ST_DTERM,
    ST_DACC,
    ST_UPD
  } state_e;

endpackage

/* sv/ipdu_mul.sv */
// Shared signed multiplier, product registered.
module ipdu_mul (
  input  logic                                clk_i,
  input  logic signed [ipdu_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ipdu_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ipdu_pkg::MUL_P_W-1:0] p_o
);

  logic signed [ipdu_pkg::MUL_P_W-1:0] p_q;
  logic signed [ipdu_pkg::MUL_P_W-1:0] p_d;

  assign p_d = ipdu_pkg::MUL_P_W'(a_i) * ipdu_pkg::MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* sv/incremental_pid_duty_update_core.sv */
// Velocity-form PID duty update (Tustin, Ts = 50 ms). Each input item is one
// sample tick carrying the pulse count and the Kp/Ki/Kd gains (unsigned Q6.16).
// The block shifts its error history, forms kp*(e[n]-e[n-1]) +
// floor(ki/40)*(e[n]+e[n-1]) + 20*kd*(e[n]-2e[n-1]+e[n-2]), which is the same
// integer as A*e[n]+B*e[n-1]+C*e[n-2], adds it (floored to Q8.16) to the duty
// accumulator and clamps to 0..duty_limit. One result item per input item:
// duty (integer part) and a saturation code. After accept an item passes the
// states DIV, PTERM, ITERM, DTERM, DACC and UPD; UPD writes the result to the
// output register: all four products (ki/40 by reciprocal, then three terms)
// go through one shared 23x28 multiplier, one per cycle, followed by a scale
// step and an update step. The block then returns to idle with ready high, so
// a new item is taken only once the last one is updated. Ready is low while
// an item is in work; a result waiting on the output does not block the next
// accept, only the next update, which then stretches the item by the cycles
// the output stays full. Config writes take effect on the clock edge.
module incremental_pid_duty_update_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // pulse_count[15:0], gain_p[37:16],
                                       // gain_i[59:38], gain_d[81:60], zeros
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // duty[7:0], saturation[9:8], zeros
);

  localparam int unsigned ErrW   = ipdu_pkg::ERR_W;
  localparam int unsigned GainW  = ipdu_pkg::GAIN_W;
  localparam int unsigned AccW   = ipdu_pkg::ACC_W;
  localparam int unsigned PW     = ipdu_pkg::MUL_P_W;
  localparam int unsigned AW     = ipdu_pkg::MUL_A_W;
  localparam int unsigned BW     = ipdu_pkg::MUL_B_W;
  localparam int unsigned KihW   = ipdu_pkg::KIH_W;
  localparam int unsigned DAccW  = ipdu_pkg::DUTY_ACC_W;
  localparam int unsigned LimW   = ipdu_pkg::LIMIT_W;
  localparam int unsigned FracW  = ipdu_pkg::DUTY_FRAC_BITS;

  // ---------------- config registers ----------------
  logic [ipdu_pkg::REF_W-1:0] ref_q;
  logic [LimW-1:0]            limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      limit_q <= ipdu_pkg::DUTY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipdu_pkg::CFG_REFERENCE:  ref_q   <= cfg_data_i[ipdu_pkg::REF_W-1:0];
        ipdu_pkg::CFG_DUTY_LIMIT: limit_q <= cfg_data_i[LimW-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // ---------------- input unpack ----------------
  logic [ipdu_pkg::PULSE_W-1:0] in_pulse;
  logic [GainW-1:0]             in_kp, in_ki, in_kd;

  assign in_pulse = s_axis_tdata_i[15:0];
  assign in_kp    = s_axis_tdata_i[37:16];
  assign in_ki    = s_axis_tdata_i[59:38];
  assign in_kd    = s_axis_tdata_i[81:60];

  // ---------------- sequencer ----------------
  ipdu_pkg::state_e state_q, state_d;

  logic                      in_acc;
  logic                      out_valid_q, out_valid_d;
  logic [ipdu_pkg::DUTY_W-1:0] duty_out_q, duty_out_d;
  logic [ipdu_pkg::SAT_W-1:0]  sat_out_q, sat_out_d;
  logic                      out_free;
  logic                      upd_go;

  assign s_axis_tready_o = (state_q == ipdu_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign upd_go          = (state_q == ipdu_pkg::ST_UPD) && out_free;

  // payload holding regs
  logic [GainW-1:0]       kp_q, ki_q, kd_q;
  logic [KihW-1:0]        kih_q;
  logic signed [ErrW-1:0] e0_q, e1_q, e2_q;   // e2 newest
  logic signed [AccW-1:0] acc_q;
  logic [DAccW-1:0]       duty_acc_q;

  // new error, Q17.8
  logic signed [ErrW-1:0] new_err;
  assign new_err = $signed({2'b00, ref_q}) - $signed({2'b00, in_pulse, 8'h00});

  // error combinations
  logic signed [ErrW:0]   err_diff, err_sum;
  logic signed [ErrW+1:0] err_d2;
  assign err_diff = (ErrW+1)'(e2_q) - (ErrW+1)'(e1_q);
  assign err_sum  = (ErrW+1)'(e2_q) + (ErrW+1)'(e1_q);
  assign err_d2   = (ErrW+2)'(e2_q) - ((ErrW+2)'(e1_q) <<< 1) + (ErrW+2)'(e0_q);

  // multiplier operand select
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ipdu_pkg::ST_IDLE: begin
        if (in_acc) state_d = ipdu_pkg::ST_DIV;
      end
      ipdu_pkg::ST_DIV: begin
        // (ki >> 3) times reciprocal of 5
        mul_a   = $signed(AW'(ki_q[GainW-1:3]));
        mul_b   = $signed(BW'(ipdu_pkg::RECIP_5));
        state_d = ipdu_pkg::ST_PTERM;
      end
      ipdu_pkg::ST_PTERM: begin
        mul_a   = $signed(AW'(kp_q));
        mul_b   = BW'(err_diff);
        state_d = ipdu_pkg::ST_ITERM;
      end
      ipdu_pkg::ST_ITERM: begin
        mul_a   = $signed(AW'(kih_q));
        mul_b   = BW'(err_sum);
        state_d = ipdu_pkg::ST_DTERM;
      end
      ipdu_pkg::ST_DTERM: begin
        mul_a   = $signed(AW'(kd_q));
        mul_b   = err_d2;
        state_d = ipdu_pkg::ST_DACC;
      end
      ipdu_pkg::ST_DACC: begin
        state_d = ipdu_pkg::ST_UPD;
      end
      ipdu_pkg::ST_UPD: begin
        if (out_free) state_d = ipdu_pkg::ST_IDLE;  // wait for output slot
      end
      default: state_d = ipdu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipdu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  ipdu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------- accumulate ----------------
  logic signed [AccW-1:0] prod_x;
  logic signed [AccW-1:0] prod_x20;
  assign prod_x   = AccW'(prod);
  assign prod_x20 = (prod_x <<< 4) + (prod_x <<< 2);

  // ---------------- duty update and clamp ----------------
  logic signed [AccW-1:0] inc;
  logic signed [AccW-1:0] next_sum;
  logic signed [AccW-1:0] top;
  logic [DAccW-1:0]       duty_acc_d;

  assign inc      = acc_q >>> ipdu_pkg::INC_SHIFT;  // floor toward minus infinity
  assign next_sum = inc + $signed(AccW'(duty_acc_q));
  assign top      = $signed(AccW'({limit_q, {FracW{1'b0}}}));

  always_comb begin
    duty_acc_d = next_sum[DAccW-1:0];
    sat_out_d  = ipdu_pkg::SAT_NONE;
    if (next_sum < 0) begin
      duty_acc_d = '0;
      sat_out_d  = ipdu_pkg::SAT_LOW;
    end else if (next_sum > top) begin
      duty_acc_d = DAccW'({limit_q, {FracW{1'b0}}});
      sat_out_d  = ipdu_pkg::SAT_HIGH;
    end
    duty_out_d = duty_acc_d[DAccW-1:FracW];
  end

  // item payload and history
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kp_q <= in_kp;
      ki_q <= in_ki;
      kd_q <= in_kd;
    end
    if (state_q == ipdu_pkg::ST_PTERM) kih_q <= prod[ipdu_pkg::RECIP_SHIFT+KihW-1:
                                                     ipdu_pkg::RECIP_SHIFT];
    case (state_q)
      ipdu_pkg::ST_ITERM: acc_q <= prod_x;              // proportional term
      ipdu_pkg::ST_DTERM: acc_q <= acc_q + prod_x;      // integral term
      ipdu_pkg::ST_DACC:  acc_q <= acc_q + prod_x20;    // derivative term, x20
      default: ;
    endcase
    if (upd_go) begin
      duty_out_q <= duty_out_d;
      sat_out_q  <= sat_out_d;
    end
  end

  // state that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q       <= '0;
      e1_q       <= '0;
      e2_q       <= '0;
      duty_acc_q <= '0;
    end else begin
      if (in_acc) begin
        e0_q <= e1_q;
        e1_q <= e2_q;
        e2_q <= new_err;
      end
      if (upd_go) duty_acc_q <= duty_acc_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (upd_go)          out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, sat_out_q, duty_out_q};

endmodule

/* test/tb_top.sv */
import ipdu_pkg::*;

// One sample tick as it travels on s_axis_tdata (pulse_count in the low bits)
typedef struct packed {
  logic [GAIN_W-1:0]  gain_d;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_p;
  logic [PULSE_W-1:0] pulse_count;
} tick_t;

// One duty update as it travels on m_axis_tdata (duty in the low bits)
typedef struct packed {
  logic [SAT_W-1:0]  saturation;
  logic [DUTY_W-1:0] duty;
} duty_result_t;

// Shadow of the controller: error history, duty accumulator, both registers,
// and the duty updates still owed by the block.
class pid_duty_model;
  logic [REF_W-1:0]        target_pulses;
  logic [LIMIT_W-1:0]      duty_limit;
  logic signed [ERR_W-1:0] err_hist [3];
  logic [DUTY_ACC_W-1:0]   duty_acc;
  duty_result_t            expected_q [$];
  int                      mismatches;

  function new();
    target_pulses = '0;
    duty_limit    = DUTY_LIMIT_RST;
    duty_acc      = '0;
    mismatches    = 0;
    foreach (err_hist[i]) err_hist[i] = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_REFERENCE:  target_pulses = data[REF_W-1:0];
      CFG_DUTY_LIMIT: duty_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_tick(tick_t t);
    longint kp, ki_q, kd, coef_a, coef_b, coef_c, acc_sum, step, acc_next, top;
    duty_result_t res;
    kp   = longint'(t.gain_p);
    ki_q = longint'(t.gain_i) / 40;  // Ki*Ts/2, truncated
    kd   = longint'(t.gain_d);
    err_hist[0] = err_hist[1];
    err_hist[1] = err_hist[2];
    err_hist[2] = ERR_W'(longint'(target_pulses) - (longint'(t.pulse_count) <<< ERR_FRAC_BITS));
    coef_a = kp + ki_q + 20 * kd;
    coef_b = -kp + ki_q - 40 * kd;
    coef_c = 20 * kd;
    acc_sum = coef_a * longint'(err_hist[2]) + coef_b * longint'(err_hist[1])
            + coef_c * longint'(err_hist[0]);
    step = acc_sum >>> INC_SHIFT;  // floor into Q8.16
    acc_next = longint'(duty_acc) + step;
    top = longint'(duty_limit) <<< DUTY_FRAC_BITS;
    res.saturation = SAT_NONE;
    if (acc_next < 0) begin
      acc_next = 0;
      res.saturation = SAT_LOW;
    end else if (acc_next > top) begin
      acc_next = top;
      res.saturation = SAT_HIGH;
    end
    duty_acc = acc_next[DUTY_ACC_W-1:0];
    res.duty = duty_acc[DUTY_ACC_W-1 -: DUTY_W];
    expected_q.push_back(res);
  endfunction

  function void check_result(duty_result_t got);
    duty_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected duty item: duty %0d sat %0d", got.duty, got.saturation);
      return;
    end
    want = expected_q.pop_front();
    if (got.duty !== want.duty || got.saturation !== want.saturation) begin
      mismatches++;
      if (mismatches <= 10)
        $display("duty item wrong at %0t: expected duty %0d sat %0d, got duty %0d sat %0d",
                 $realtime, want.duty, want.saturation, got.duty, got.saturation);
    end
  endfunction
endclass

module tb_top;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  // wait before a register write, with slack over an item's accept-to-result time
  localparam int SETTLE_CYCLES = 10;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 58;
  localparam int MAX_CYCLES    = 600000;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 22'(1 << GAIN_FRAC_BITS);

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        s_valid = 1'b0;
  logic [87:0] s_data  = '0;
  logic        s_axis_tready_o;

  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata_o;

  // idle odds in percent per cycle, set per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // one-shot request for a long receiver hold-off
  bit hold_req = 1'b0;

  // register values currently programmed, used to aim the stimulus
  logic [REF_W-1:0] cur_target = '0;

  pid_duty_model duty_model = new();

  incremental_pid_duty_update_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, or a long hold when asked. The hold is
  // counted here so the sender keeps pushing items while it runs.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result check at the handshake edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      duty_model.check_result(duty_result_t'(m_axis_tdata_o[SAT_W+DUTY_W-1:0]));
  end

  // Present one tick, idling at random first; returns right after the accept edge.
  task automatic send_tick(tick_t t);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, t};
    do @(posedge clk_i); while (!s_axis_tready_o);
    duty_model.note_tick(t);
  endtask

  // Drop valid and wait until every owed duty item has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (duty_model.pending() != 0) @(posedge clk_i);
  endtask

  // Register write, only with the block drained and idle
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    duty_model.write_reg(idx, data);
    if (idx == CFG_REFERENCE) cur_target = data[REF_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic tick_t make_tick(int unsigned pulse, logic [GAIN_W-1:0] kp,
                                      logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd);
    tick_t t;
    t.pulse_count = pulse[PULSE_W-1:0];
    t.gain_p = kp;
    t.gain_i = ki;
    t.gain_d = kd;
    return t;
  endfunction

  // Mostly a loop near its set point (count within a few pulses of the
  // target, modest gains) so the accumulator wanders between the clamps;
  // the rest is raw noise over the full field ranges.
  function automatic tick_t random_tick(logic [REF_W-1:0] target);
    tick_t t;
    int    base;
    if ($urandom_range(99) < 75) begin
      base = int'(target >> ERR_FRAC_BITS) + int'($urandom_range(16)) - 8;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      t.pulse_count = base[PULSE_W-1:0];
      t.gain_p = GAIN_W'($urandom_range(1 << 18));
      t.gain_i = GAIN_W'($urandom_range(1 << 20));
      t.gain_d = GAIN_W'($urandom_range(1 << 13));
    end else begin
      t.pulse_count = PULSE_W'($urandom);
      t.gain_p = GAIN_W'($urandom);
      t.gain_i = GAIN_W'($urandom);
      t.gain_d = GAIN_W'($urandom);
    end
    return t;
  endfunction

  initial begin
    logic [REF_W-1:0]   new_target;
    logic [LIMIT_W-1:0] new_limit;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed: bounds, clamps, truncation, register corner cases ----
    // target of 250 pulses, reset limit of 250
    set_register(CFG_REFERENCE, 24'(250 << ERR_FRAC_BITS));
    send_tick(make_tick(250, '0, '0, '0));               // zero error, zero sum
    send_tick(make_tick(0, GAIN_ONE, '0, '0));           // lands exactly on the limit
    send_tick(make_tick(0, GAIN_ONE, '0, '0));           // no change, still on the limit
    send_tick(make_tick(0, '0, 22'(40 << GAIN_FRAC_BITS), '0)); // overshoots: clamp high
    send_tick(make_tick(500, GAIN_ONE, '0, '0));         // undershoots: clamp low
    send_tick(make_tick(250, GAIN_ONE, '0, '0));         // from zero up to the limit
    send_tick(make_tick(500, GAIN_ONE, '0, '0));         // back down to exactly zero
    send_tick(make_tick(249, '0, 22'd79, '0));           // Ki/40 truncates
    send_tick(make_tick(250, '0, '0, GAIN_ONE));         // derivative term only
    send_tick(make_tick(16'hFFFF, GAIN_MAX, GAIN_MAX, GAIN_MAX));
    send_tick(make_tick(0, GAIN_MAX, GAIN_MAX, GAIN_MAX));
    send_tick(make_tick(16'hFFFF, '0, '0, '0));
    // zero limit, with junk in the unused upper data bits
    set_register(CFG_DUTY_LIMIT, 24'hABCD00);
    send_tick(make_tick(0, GAIN_ONE, '0, '0));           // positive sum pinned: clamp high
    send_tick(make_tick(250, '0, '0, '0));               // zero sum on a zero limit
    // writes to undecoded indexes must change nothing
    set_register(CFG_SPARE_2, 24'h123456);
    set_register(CFG_SPARE_3, 24'hFFFFFF);
    send_tick(make_tick(250, GAIN_ONE, GAIN_ONE, '0));
    // top of both register ranges
    set_register(CFG_REFERENCE, 24'hFFFFFF);
    set_register(CFG_DUTY_LIMIT, 24'hFF00FF);
    send_tick(make_tick(0, GAIN_MAX, '0, '0));
    send_tick(make_tick(16'hFFFF, 22'd1, '0, '0));
    send_tick(make_tick(0, '0, '0, GAIN_MAX));

    // ---- random: three idling modes, four register settings each ----
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 37; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin
            new_target = REF_W'($urandom_range(2000) << ERR_FRAC_BITS)
                       | REF_W'($urandom_range(255));
            new_limit  = DUTY_LIMIT_RST;
          end
          1: begin
            new_target = '1;
            new_limit  = '1;
          end
          2: begin
            new_target = (mode == 0) ? '0 : REF_W'($urandom);
            new_limit  = (mode == 1) ? '0 : LIMIT_W'($urandom_range(1, 254));
          end
          default: begin
            new_target = REF_W'($urandom);
            new_limit  = LIMIT_W'($urandom);
          end
        endcase
        set_register(CFG_REFERENCE, new_target);
        set_register(CFG_DUTY_LIMIT, {16'($urandom), new_limit});
        if (k == 3) set_register(($urandom_range(1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                                 24'($urandom));
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // long receiver stall while ticks keep coming: block fills and stalls its input
          if (n == 20 && k == 1) hold_req = 1'b1;
          // sender stands back until the block has emptied
          if (n == 30 && k == 2) wait_for_results();
          send_tick(random_tick(cur_target));
        end
      end
    end

    wait_for_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (duty_model.mismatches == 0 && duty_model.pending() == 0) begin
      $display("incremental_pid_duty_update_core: match");
    end else begin
      $display("incremental_pid_duty_update_core: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("incremental_pid_duty_update_core: mismatch");
    $finish;
  end

endmodule
